@@ rtl/mtfd_pkg.sv @@
package mtfd_pkg;

    // Delay store geometry. The store is addressed modulo its depth, so the
    // depth is a power of two.
    localparam int DEPTH         = 131072;
    localparam int ADDR_BITS     = $clog2(DEPTH);
    localparam int SAMPLE_BITS   = 24;
    localparam int FRACTION_BITS = 8;
    localparam int TAP_COUNT     = 4;
    localparam int TAP_IDX_BITS  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

    // Register field widths.
    localparam int MAIN_DELAY_BITS = 25;
    localparam int DELAY_INT_BITS  = MAIN_DELAY_BITS - FRACTION_BITS;
    localparam int GAIN_BITS       = 16;
    localparam int GAIN_SHIFT      = 15;
    localparam int MIX_BITS        = 16;
    localparam int CTRL_BITS       = 2;
    localparam int TAP_DELAY_BITS  = 17;
    localparam int TAP_BITS        = TAP_DELAY_BITS + GAIN_BITS;
    localparam logic [MIX_BITS-1:0] MIX_RESET = MIX_BITS'(16384);

    localparam int CTRL_BYPASS  = 0;
    localparam int CTRL_EXT_FB  = 1;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = TAP_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAIN_DELAY = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FB_GAIN    = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIX_LEVEL  = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CONTROL    = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_ONE    = 4'd4;

    // Stream payload: two samples packed, padded to whole bytes.
    localparam int STREAM_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    // Datapath widths. The wet sum holds the interpolated sample plus up to
    // four tap terms, each no wider than a sample.
    localparam int ACC_BITS   = SAMPLE_BITS + 4;
    localparam int MUL_A_BITS = GAIN_BITS + 1;
    localparam int MUL_B_BITS = ACC_BITS;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int WIDE_BITS  = SAMPLE_BITS + 8;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [WIDE_BITS-1:0]   t_wide;

    localparam t_wide SAT_HI = WIDE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam t_wide SAT_LO = -SAT_HI - WIDE_BITS'(1);

    function automatic t_sample sat_sample(input t_wide v);
        t_sample res;
        if (v > SAT_HI) begin
            res = SAMPLE_BITS'(SAT_HI);
        end else if (v < SAT_LO) begin
            res = SAMPLE_BITS'(SAT_LO);
        end else begin
            res = SAMPLE_BITS'(v);
        end
        return res;
    endfunction

endpackage

@@ rtl/multi_tap_fractional_delay.sv @@
// Channel        Direction  Handshake                     Payload
// s_axis         in         s_axis_tvalid/s_axis_tready   sample_in, external_feedback_in
// m_axis         out        m_axis_tvalid/m_axis_tready   sample_out, feedback_send
// cfg            in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// The single read port of the delay store sets how long a sample takes, with six
// reads before the write and one after it, and one shared multiplier used once per
// cycle except while a finished result waits; bypass goes straight to the feedback read.
// The next sample is taken while a finished result waits in the output register.
// Reset is synchronous; the store is not cleared, a fill mark (write index plus
// a wrapped flag) makes never-written entries read as zero, so there is no clearing pass.
// The configuration port is always ready.
module multi_tap_fractional_delay (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [23:0] sample_in, [47:24] external_feedback_in
    input  logic [mtfd_pkg::STREAM_BITS-1:0]      s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [23:0] sample_out, [47:24] feedback_send
    output logic [mtfd_pkg::STREAM_BITS-1:0]      m_axis_tdata,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mtfd_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [mtfd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    import mtfd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TAP  = 4'd1;
    localparam logic [3:0] S_RA   = 4'd2;
    localparam logic [3:0] S_RB   = 4'd3;
    localparam logic [3:0] S_DIF  = 4'd4;
    localparam logic [3:0] S_INT  = 4'd5;
    localparam logic [3:0] S_Y    = 4'd6;
    localparam logic [3:0] S_FB   = 4'd7;
    localparam logic [3:0] S_WR   = 4'd8;
    localparam logic [3:0] S_FBR  = 4'd9;
    localparam logic [3:0] S_FBM  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    // Configuration registers.
    logic [MAIN_DELAY_BITS-1:0]   r_main_delay;
    logic signed [GAIN_BITS-1:0]  r_fb_gain;
    logic [MIX_BITS-1:0]          r_mix;
    logic [CTRL_BITS-1:0]         r_ctrl;
    logic [TAP_BITS-1:0]          r_tap [TAP_COUNT];

    // Sequencer and store bookkeeping.
    logic [3:0]                   r_state;
    logic [TAP_IDX_BITS-1:0]      r_tap_cnt;
    logic [TAP_IDX_BITS-1:0]      r_tk;
    logic                         r_tv;
    logic                         r_pv;
    logic                         r_rv;
    logic [ADDR_BITS-1:0]         r_widx;
    logic                         r_wrap;
    logic                         r_ov;

    // Sample datapath.
    t_sample                      r_x;
    t_sample                      r_ext;
    t_sample                      r_a;
    logic signed [SAMPLE_BITS:0]  r_diff;
    t_sample                      r_y;
    logic signed [ACC_BITS-1:0]   r_acc;
    logic signed [ACC_BITS-1:0]   r_wd;
    logic signed [PROD_BITS-1:0]  r_prod;
    t_sample                      r_out;
    t_sample                      r_out_o;
    t_sample                      r_fbs_o;

    logic [DELAY_INT_BITS-1:0]    d_int;
    logic [FRACTION_BITS-1:0]     d_frac;
    logic [ADDR_BITS-1:0]         d_addr;
    logic [TAP_DELAY_BITS-1:0]    tap_delay [TAP_COUNT];
    logic signed [GAIN_BITS-1:0]  tap_level [TAP_COUNT];

    logic [ADDR_BITS-1:0]         rd_addr;
    logic                         rd_ok;
    logic [SAMPLE_BITS-1:0]       ram_q;
    t_sample                      rd_val;
    logic                         ram_we;
    t_sample                      wr_data;
    logic signed [MUL_A_BITS-1:0] mul_a;
    logic signed [MUL_B_BITS-1:0] mul_b;
    t_wide                        prod_g;
    t_wide                        interp;
    logic                         in_xfer;
    logic                         out_free;

    assign d_int   = r_main_delay[MAIN_DELAY_BITS-1:FRACTION_BITS];
    assign d_frac  = r_main_delay[FRACTION_BITS-1:0];
    assign d_addr  = ADDR_BITS'(d_int);

    always_comb begin
        for (int k = 0; k < TAP_COUNT; k++) begin
            tap_delay[k] = r_tap[k][TAP_DELAY_BITS-1:0];
            tap_level[k] = r_tap[k][TAP_BITS-1:TAP_DELAY_BITS];
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ov || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = STREAM_BITS'({r_fbs_o, r_out_o});

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_delay <= '0;
            r_fb_gain    <= '0;
            r_mix        <= MIX_RESET;
            r_ctrl       <= '0;
            for (int k = 0; k < TAP_COUNT; k++) begin
                r_tap[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAIN_DELAY: r_main_delay <= i_cfg_data[MAIN_DELAY_BITS-1:0];
                CFG_FB_GAIN:    r_fb_gain    <= i_cfg_data[GAIN_BITS-1:0];
                CFG_MIX_LEVEL:  r_mix        <= i_cfg_data[MIX_BITS-1:0];
                CFG_CONTROL:    r_ctrl       <= i_cfg_data[CTRL_BITS-1:0];
                default: ;
            endcase
            for (int k = 0; k < TAP_COUNT; k++) begin
                if (i_cfg_index == CFG_TAP_ONE + CFG_INDEX_BITS'(k)) begin
                    r_tap[k] <= i_cfg_data[TAP_BITS-1:0];
                end
            end
        end
    end

    // Read address for the current step. Write index is already advanced in S_FBR.
    always_comb begin
        case (r_state)
            S_TAP:   rd_addr = r_widx - ADDR_BITS'(tap_delay[r_tap_cnt]);
            S_RB:    rd_addr = r_widx - d_addr - ADDR_BITS'(1);
            default: rd_addr = r_widx - d_addr;
        endcase
    end

    // Entries are written in index order, so an entry holds data once the
    // write index has passed it or the index has wrapped.
    assign rd_ok  = r_wrap || (rd_addr < r_widx);
    assign rd_val = r_rv ? t_sample'(ram_q) : '0;

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_tv) begin
            mul_a = (tap_delay[r_tk] != '0) ? MUL_A_BITS'(tap_level[r_tk]) : '0;
            mul_b = MUL_B_BITS'(rd_val);
        end
        case (r_state)
            S_INT: begin
                mul_a = MUL_A_BITS'(d_frac);
                mul_b = MUL_B_BITS'(r_diff);
            end
            S_FB: begin
                mul_a = MUL_A_BITS'(r_fb_gain);
                mul_b = MUL_B_BITS'(r_y);
            end
            S_WR: begin
                mul_a = MUL_A_BITS'(r_mix);
                mul_b = r_wd;
            end
            S_FBM: begin
                mul_a = MUL_A_BITS'(r_fb_gain);
                mul_b = MUL_B_BITS'(rd_val);
            end
            default: ;
        endcase
    end

    assign prod_g = WIDE_BITS'(r_prod >>> GAIN_SHIFT);
    // (2^F - f)*a + f*b equals 2^F*a + f*(b - a), so only one product is needed.
    assign interp = WIDE_BITS'(r_a) + WIDE_BITS'(r_prod >>> FRACTION_BITS);

    assign ram_we  = (r_state == S_WR);
    assign wr_data = r_ctrl[CTRL_EXT_FB] ? sat_sample(WIDE_BITS'(r_x) + WIDE_BITS'(r_ext))
                                         : sat_sample(WIDE_BITS'(r_x) + prod_g);

    mtfd_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(DEPTH),
        .ADDR_BITS(ADDR_BITS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_widx),
        .i_wdata(wr_data),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tap_cnt <= '0;
            r_tk      <= '0;
            r_tv      <= 1'b0;
            r_pv      <= 1'b0;
            r_rv      <= 1'b0;
            r_widx    <= '0;
            r_wrap    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_rv <= rd_ok;
            r_tv <= (r_state == S_TAP);
            r_tk <= r_tap_cnt;
            r_pv <= r_tv;
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_tap_cnt <= '0;
                    if (in_xfer) begin
                        r_state <= r_ctrl[CTRL_BYPASS] ? S_FBR : S_TAP;
                    end
                end
                S_TAP: begin
                    r_tap_cnt <= r_tap_cnt + TAP_IDX_BITS'(1);
                    if (r_tap_cnt == TAP_IDX_BITS'(TAP_COUNT - 1)) begin
                        r_state <= S_RA;
                    end
                end
                S_RA:  r_state <= S_RB;
                S_RB:  r_state <= S_DIF;
                S_DIF: r_state <= S_INT;
                S_INT: r_state <= S_Y;
                S_Y:   r_state <= S_FB;
                S_FB:  r_state <= S_WR;
                S_WR: begin
                    r_widx <= r_widx + ADDR_BITS'(1);
                    if (r_widx == '1) begin
                        r_wrap <= 1'b1;
                    end
                    r_state <= S_FBR;
                end
                S_FBR: r_state <= S_FBM;
                S_FBM: r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Sample datapath.
    always_ff @(posedge i_clk) begin
        // The feedback product is held while a finished result waits.
        if (r_state != S_DONE) begin
            r_prod <= mul_a * mul_b;
        end
        if (in_xfer) begin
            r_x   <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_ext <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_BITS'(prod_g);
        end
        if (r_state == S_RB) begin
            r_a <= rd_val;
        end
        if (r_state == S_DIF) begin
            r_diff <= (SAMPLE_BITS + 1)'(rd_val) - (SAMPLE_BITS + 1)'(r_a);
        end
        if (r_state == S_Y) begin
            r_y <= (d_int == '0) ? r_x : SAMPLE_BITS'(interp);
        end
        if (r_state == S_FB) begin
            r_wd <= r_acc + ACC_BITS'(r_y) - ACC_BITS'(r_x);
        end
        // Dry/wet mix: x + mix*(wet - x) >> 15 gives the same value as the
        // weighted sum of both shares.
        if (r_state == S_FBR) begin
            r_out <= r_ctrl[CTRL_BYPASS] ? r_x : sat_sample(WIDE_BITS'(r_x) + prod_g);
        end
        if (r_state == S_DONE && out_free) begin
            r_out_o <= r_out;
            r_fbs_o <= sat_sample(prod_g);
        end
    end

    a_widx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_widx == ADDR_BITS'($past(r_widx) + ADDR_BITS'(1)))
        else $error("write index did not advance after a store write");

    a_widx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ram_we |=> $stable(r_widx))
        else $error("write index moved without a store write");

    a_bypass_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !r_ctrl[CTRL_BYPASS])
        else $error("store written in bypass");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state != S_IDLE)
        else $error("sequencer did not start after an input transfer");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_ov && r_state == S_IDLE))
        else $error("finished result not presented");

endmodule

@@ rtl/mtfd_ram.sv @@
module mtfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // A read in the same cycle as a write to the same entry returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule
